>>> src/sha1hc_pkg.sv
// Shared types and constants for the SHA-1 hash core.
package sha1hc_pkg;

	typedef logic [31:0] word_t;
	typedef logic [6:0]  round_idx_t;

	// Working variables a through e of the compression rounds.
	typedef struct packed {
		word_t a;
		word_t b;
		word_t c;
		word_t d;
		word_t e;
	} work_t;

	localparam round_idx_t LAST_ROUND = 7'd79;

	localparam word_t IV0 = 32'h67452301;
	localparam word_t IV1 = 32'hEFCDAB89;
	localparam word_t IV2 = 32'h98BADCFE;
	localparam word_t IV3 = 32'h10325476;
	localparam word_t IV4 = 32'hC3D2E1F0;

	localparam word_t K0 = 32'h5A827999;
	localparam word_t K1 = 32'h6ED9EBA1;
	localparam word_t K2 = 32'h8F1BBCDC;
	localparam word_t K3 = 32'hCA62C1D6;

	localparam word_t PAD_WORD = 32'h80000000;

endpackage

>>> src/sha1_hash_core.sv
// SHA-1 hash core: message words in, five digest words out.
//
// Input channel s_axis: one big-endian message word per transfer, first byte
// in bits 31:24. tuser carries the count of valid bytes, which matters only on
// the word marked by tlast; a count above four is taken as four.
// Output channel m_axis: after a last word, five transfers carry h0..h4, with
// the word index in tuser and tlast on h4.
//
// Flow: a word is taken whenever the block is idle. Every sixteenth word starts
// a block compression on the single shared round unit: the rounds, then a fold
// into the chaining words, during which s_axis_tready is low and no new word is
// taken. After the last word, the padding words are pushed one after another
// and the padding needs one or two compressions, then the digest is presented.
// The block takes no input while the digest is pending; if the receiver
// stalls, the current digest word is held until taken. After h4 is taken the
// chaining words, word count and bit length return to their initial values.
// Reset puts the block idle and ready with the initial chaining values.
module sha1_hash_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [31:0] data_word
	input  logic [2:0]  s_axis_tuser,   // [2:0] bytes_valid
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] digest_word
	output logic [2:0]  m_axis_tuser,   // [2:0] word_index
	output logic        m_axis_tlast
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUND,
		ST_FINAL,
		ST_PAD,
		ST_OUT
	} state_t;

	state_t                 state_q;
	sha1hc_pkg::word_t      chain_q [5];
	sha1hc_pkg::word_t      sched_q [16];
	sha1hc_pkg::work_t      work_q;
	sha1hc_pkg::work_t      work_nxt;
	sha1hc_pkg::round_idx_t rnd_q;
	logic [3:0]             count_q;
	logic [63:0]            len_q;
	logic                   fin_q;
	logic                   pad80_q;
	logic                   len_done_q;
	logic [2:0]             out_idx_q;

	logic                   s_fire;
	logic                   m_fire;
	logic [2:0]             nbytes;
	logic [31:0]            keep_mask;
	logic [31:0]            pad_bit;
	logic                   shift_en;
	sha1hc_pkg::word_t      shift_in;
	sha1hc_pkg::word_t      sched_new;
	logic [63:0]            len_inc;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = (state_q == ST_OUT);
	assign s_fire        = s_axis_tvalid && s_axis_tready;
	assign m_fire        = m_axis_tvalid && m_axis_tready;
	assign m_axis_tdata  = chain_q[out_idx_q];
	assign m_axis_tuser  = out_idx_q;
	assign m_axis_tlast  = (out_idx_q == 3'd4);

	assign nbytes  = (s_axis_tuser > 3'd4) ? 3'd4 : s_axis_tuser;
	assign len_inc = s_axis_tlast ? {58'd0, nbytes, 3'b000} : 64'd32;

	always_comb begin
		case (nbytes[1:0])
			2'd0: begin
				keep_mask = 32'h00000000;
				pad_bit   = 32'h80000000;
			end
			2'd1: begin
				keep_mask = 32'hFF000000;
				pad_bit   = 32'h00800000;
			end
			2'd2: begin
				keep_mask = 32'hFFFF0000;
				pad_bit   = 32'h00008000;
			end
			default: begin
				keep_mask = 32'hFFFFFF00;
				pad_bit   = 32'h00000080;
			end
		endcase
	end

	// Next schedule word: w[t+16] = rotl1(w[t+13] ^ w[t+8] ^ w[t+2] ^ w[t]).
	always_comb begin
		sched_new = sched_q[13] ^ sched_q[8] ^ sched_q[2] ^ sched_q[0];
		sched_new = {sched_new[30:0], sched_new[31]};
	end

	// The schedule shifts once per pushed word and once per round.
	always_comb begin
		shift_en = 1'b0;
		shift_in = sched_new;
		case (state_q)
			ST_IDLE: begin
				shift_en = s_fire;
				if (!s_axis_tlast || nbytes == 3'd4) begin
					shift_in = s_axis_tdata;
				end else begin
					shift_in = (s_axis_tdata & keep_mask) | pad_bit;
				end
			end
			ST_PAD: begin
				shift_en = 1'b1;
				if (pad80_q) begin
					shift_in = sha1hc_pkg::PAD_WORD;
				end else if (count_q == 4'd14) begin
					shift_in = len_q[63:32];
				end else if (count_q == 4'd15) begin
					// The low length word follows only if the high one went in at slot 14.
					shift_in = len_done_q ? len_q[31:0] : '0;
				end else begin
					shift_in = '0;
				end
			end
			ST_ROUND: begin
				shift_en = 1'b1;
			end
			default: begin
				shift_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			for (int i = 0; i < 15; i++) begin
				sched_q[i] <= sched_q[i + 1];
			end
			sched_q[15] <= shift_in;
		end
	end

	sha1hc_round u_round (
		.cur (work_q),
		.rnd (rnd_q),
		.w   (sched_q[0]),
		.nxt (work_nxt)
	);

	always_ff @(posedge clk) begin
		if (state_q == ST_ROUND) begin
			work_q <= work_nxt;
		end else begin
			work_q <= '{a: chain_q[0], b: chain_q[1], c: chain_q[2],
				d: chain_q[3], e: chain_q[4]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			chain_q[0] <= sha1hc_pkg::IV0;
			chain_q[1] <= sha1hc_pkg::IV1;
			chain_q[2] <= sha1hc_pkg::IV2;
			chain_q[3] <= sha1hc_pkg::IV3;
			chain_q[4] <= sha1hc_pkg::IV4;
			rnd_q      <= '0;
			count_q    <= '0;
			len_q      <= '0;
			fin_q      <= 1'b0;
			pad80_q    <= 1'b0;
			len_done_q <= 1'b0;
			out_idx_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					rnd_q <= '0;
					if (s_fire) begin
						len_q   <= len_q + len_inc;
						count_q <= count_q + 4'd1;
						if (s_axis_tlast) begin
							fin_q   <= 1'b1;
							pad80_q <= (nbytes == 3'd4);
						end
						if (count_q == 4'd15) begin
							state_q <= ST_ROUND;
						end else if (s_axis_tlast) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					rnd_q   <= '0;
					count_q <= count_q + 4'd1;
					if (pad80_q) begin
						pad80_q <= 1'b0;
					end else if (count_q == 4'd14) begin
						len_done_q <= 1'b1;
					end
					if (count_q == 4'd15) begin
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q == sha1hc_pkg::LAST_ROUND) begin
						state_q <= ST_FINAL;
					end
				end
				ST_FINAL: begin
					chain_q[0] <= chain_q[0] + work_q.a;
					chain_q[1] <= chain_q[1] + work_q.b;
					chain_q[2] <= chain_q[2] + work_q.c;
					chain_q[3] <= chain_q[3] + work_q.d;
					chain_q[4] <= chain_q[4] + work_q.e;
					if (len_done_q) begin
						state_q <= ST_OUT;
					end else if (fin_q) begin
						state_q <= ST_PAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_OUT: begin
					if (m_fire) begin
						if (out_idx_q == 3'd4) begin
							chain_q[0] <= sha1hc_pkg::IV0;
							chain_q[1] <= sha1hc_pkg::IV1;
							chain_q[2] <= sha1hc_pkg::IV2;
							chain_q[3] <= sha1hc_pkg::IV3;
							chain_q[4] <= sha1hc_pkg::IV4;
							count_q    <= '0;
							len_q      <= '0;
							fin_q      <= 1'b0;
							pad80_q    <= 1'b0;
							len_done_q <= 1'b0;
							out_idx_q  <= '0;
							state_q    <= ST_IDLE;
						end else begin
							out_idx_q <= out_idx_q + 3'd1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Input and output are never open at the same time.
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid))
		else $error("input ready while digest is pending");

	// A last word never produces a digest in the very next cycle.
	a_last_pads: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire && s_axis_tlast |=> !m_axis_tvalid)
		else $error("digest presented without padding");

	// The fold into the chaining words follows only the final round.
	a_final_after_round: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FINAL |-> $past(state_q) == ST_ROUND
			&& $past(rnd_q) == sha1hc_pkg::LAST_ROUND)
		else $error("fold without a full set of rounds");

	// The digest is only presented with the whole block count consumed.
	a_out_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> count_q == 4'd0 && len_done_q)
		else $error("digest presented mid-block");

	// Taking h4 re-arms the block for a new message.
	a_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		m_fire && m_axis_tlast |=> s_axis_tready && len_q == 64'd0)
		else $error("block not re-armed after digest");

endmodule

>>> src/sha1hc_round.sv
// One SHA-1 compression round: round function, constant and the five-way update.
module sha1hc_round (
	input  sha1hc_pkg::work_t      cur,
	input  sha1hc_pkg::round_idx_t rnd,
	input  sha1hc_pkg::word_t      w,
	output sha1hc_pkg::work_t      nxt
);

	sha1hc_pkg::word_t f;
	sha1hc_pkg::word_t k;
	sha1hc_pkg::word_t tmp;

	always_comb begin
		if (rnd < 7'd20) begin
			f = (cur.b & cur.c) | (~cur.b & cur.d);
			k = sha1hc_pkg::K0;
		end else if (rnd < 7'd40) begin
			f = cur.b ^ cur.c ^ cur.d;
			k = sha1hc_pkg::K1;
		end else if (rnd < 7'd60) begin
			f = (cur.b & cur.c) | (cur.b & cur.d) | (cur.c & cur.d);
			k = sha1hc_pkg::K2;
		end else begin
			f = cur.b ^ cur.c ^ cur.d;
			k = sha1hc_pkg::K3;
		end
		tmp = {cur.a[26:0], cur.a[31:27]} + f + cur.e + k + w;
		nxt.a = tmp;
		nxt.b = cur.a;
		nxt.c = {cur.b[1:0], cur.b[31:2]};
		nxt.d = cur.c;
		nxt.e = cur.d;
	end

endmodule
